// File: hw/rtl/crc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc_pkg;

   localparam int ENTRY_COUNT_DEFAULT = 16;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   typedef struct packed {
      logic               op;
      logic [15:0]        req_ident;
      logic [15:0]        cmd_ident;
      logic signed [15:0] new_result;
      logic [15:0]        new_detail;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] found_result;
      logic [15:0]        found_detail;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        req_ident;
      logic [15:0]        cmd_ident;
      logic signed [15:0] outcome;
      logic [15:0]        extra;
   } entry_type;

   typedef struct packed {
      logic               valid;
      logic [15:0]        req_ident;
      logic [15:0]        cmd_ident;
      logic               hit;
      logic signed [15:0] found_result;
      logic [15:0]        found_detail;
   } token_type;

endpackage

`default_nettype wire

// File: hw/rtl/crc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module crc_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       write_en,
   input  wire crc_pkg::entry_type   write_entry,
   input  wire crc_pkg::token_type   tok_in,
   output crc_pkg::token_type        tok_out
);

   logic                 valid_ff;
   crc_pkg::entry_type   entry_ff;
   crc_pkg::token_type   tok_ff;
   crc_pkg::token_type   tok_in_next;
   logic                 match;

   assign match = tok_in.valid && !tok_in.hit && valid_ff &&
                  (entry_ff.req_ident == tok_in.req_ident) &&
                  (entry_ff.cmd_ident == tok_in.cmd_ident);

   always_comb begin
      tok_in_next = tok_in;
      if (match) begin
         tok_in_next.hit          = 1'b1;
         tok_in_next.found_result = entry_ff.outcome;
         tok_in_next.found_detail = entry_ff.extra;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= write_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// File: hw/rtl/command_replay_cache.sv
// record: result strobe in the cycle after the accepting edge, busy stays low, one per cycle while busy is low
// lookup: the search travels the cell chain one cell per cycle, and the strobe is registered
// from the last cell's output; busy is high until then, and no new request is taken while busy
// each result is held for exactly one cycle; the receiver cannot stall
// synchronous reset clears all valid marks, the insert pointer and any search in flight
`timescale 1ns / 1ps
`default_nettype none

module command_replay_cache #(
   parameter int ENTRY_COUNT = crc_pkg::ENTRY_COUNT_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire crc_pkg::req_type   req_data,
   output logic                    rsp_strobe,
   output crc_pkg::rsp_type        rsp_data
);

   localparam int PTR_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   logic                 accept;
   logic                 record_accept;
   logic                 lookup_accept;
   logic                 busy_ff, busy_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   crc_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   crc_pkg::token_type   tok_ff, tok_in;
   crc_pkg::entry_type   write_entry;
   crc_pkg::token_type   chain [0:ENTRY_COUNT];

   assign accept        = start && !busy_ff;
   assign record_accept = accept && (req_data.op == crc_pkg::OP_RECORD);
   assign lookup_accept = accept && (req_data.op == crc_pkg::OP_LOOKUP);

   assign write_entry.req_ident = req_data.req_ident;
   assign write_entry.cmd_ident = req_data.cmd_ident;
   assign write_entry.outcome   = req_data.new_result;
   assign write_entry.extra     = req_data.new_detail;

   always_comb begin
      tok_in              = tok_ff;
      tok_in.valid        = lookup_accept;
      if (lookup_accept) begin
         tok_in.req_ident    = req_data.req_ident;
         tok_in.cmd_ident    = req_data.cmd_ident;
         tok_in.hit          = 1'b0;
         tok_in.found_result = '0;
         tok_in.found_detail = '0;
      end
   end

   assign chain[0] = tok_ff;

   for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
      crc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .write_en    (record_accept && (ptr_ff == PTR_W'(i))),
         .write_entry (write_entry),
         .tok_in      (chain[i]),
         .tok_out     (chain[i+1])
      );
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (record_accept) begin
         if (ptr_ff == PTR_W'(ENTRY_COUNT - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + PTR_W'(1);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (lookup_accept) begin
         busy_in = 1'b1;
      end else if (chain[ENTRY_COUNT].valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_strobe_in = record_accept || chain[ENTRY_COUNT].valid;
      rsp_data_in   = '0;
      if (chain[ENTRY_COUNT].valid && chain[ENTRY_COUNT].hit) begin
         rsp_data_in.hit          = 1'b1;
         rsp_data_in.found_result = chain[ENTRY_COUNT].found_result;
         rsp_data_in.found_detail = chain[ENTRY_COUNT].found_detail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         ptr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         tok_ff.valid  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         ptr_ff        <= ptr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         tok_ff        <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire
